FILE: rtl/button_gesture_classifier_top_defines.svh
// assertion macros of the button gesture classifier rtl, used by bgc_core
`ifndef BUTTON_GESTURE_CLASSIFIER_TOP_DEFINES_SVH
`define BUTTON_GESTURE_CLASSIFIER_TOP_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define BGC_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent in a cycle implies consequent in the next
`define BGC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bgc_pkg.sv
// types and constants of the button gesture classifier
package bgc_pkg;

    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_PUSH    = 2'd1,
        REQ_RELEASE = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        GESTURE_CLICK     = 2'd0,
        GESTURE_DOUBLE    = 2'd1,
        GESTURE_LONG      = 2'd2,
        GESTURE_LONG_LONG = 2'd3
    } gesture_t;

    typedef enum logic [1:0] {
        CFG_LONG_PERIOD_TICKS   = 2'd0,
        CFG_DOUBLE_WINDOW_TICKS = 2'd1,
        CFG_LONG_THRESHOLD      = 2'd2,
        CFG_LONG_LONG_THRESHOLD = 2'd3
    } cfg_index_t;

    localparam logic [15:0] LONG_PERIOD_RESET   = 16'd100;
    localparam logic [15:0] DOUBLE_WINDOW_RESET = 16'd350;
    localparam logic [7:0]  LONG_THRESH_RESET   = 8'(1700 / 100);
    localparam logic [7:0]  LONG_LONG_RESET     = 8'(7000 / 100);
    localparam logic [7:0]  HELD_MAX            = 8'd255;

    typedef struct packed {
        logic [15:0] long_period_ticks;
        logic [15:0] double_window_ticks;
        logic [7:0]  long_threshold;
        logic [7:0]  long_long_threshold;
    } cfg_t;

    typedef struct packed {
        logic     valid;
        gesture_t code;
    } result_t;

endpackage

FILE: rtl/button_gesture_classifier_top.sv
// top level of the button gesture classifier
// Takes one tick, push or release item per cycle and updates the gesture state in the
// cycle of the transfer; a result, when the item gives one, is registered into a two-entry
// result buffer and offered on the output from there. in_stall rises only while that
// buffer holds two undelivered results, so with the output side taking results the block
// runs at one item per cycle. Configuration writes are always accepted and registered.
module button_gesture_classifier_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic        button_level,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  gesture_code,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    bgc_pkg::cfg_t    cfg;
    bgc_pkg::result_t result;
    logic             full;
    logic             accept;

    assign in_stall = full;
    assign accept   = in_valid && !in_stall;

    bgc_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bgc_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .req_type     (req_type),
        .button_level (button_level),
        .cfg          (cfg),
        .result       (result)
    );

    bgc_out_buf u_out_buf
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .result       (result),
        .full         (full),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .gesture_code (gesture_code)
    );

endmodule

FILE: rtl/bgc_cfg_regs.sv
// configuration register file of the button gesture classifier
module bgc_cfg_regs
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_data,
    output bgc_pkg::cfg_t cfg
);

    bgc_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_period_ticks   <= bgc_pkg::LONG_PERIOD_RESET;
            cfg_reg.double_window_ticks <= bgc_pkg::DOUBLE_WINDOW_RESET;
            cfg_reg.long_threshold      <= bgc_pkg::LONG_THRESH_RESET;
            cfg_reg.long_long_threshold <= bgc_pkg::LONG_LONG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (bgc_pkg::cfg_index_t'(cfg_index))
                bgc_pkg::CFG_LONG_PERIOD_TICKS:   cfg_reg.long_period_ticks   <= cfg_data;
                bgc_pkg::CFG_DOUBLE_WINDOW_TICKS: cfg_reg.double_window_ticks <= cfg_data;
                bgc_pkg::CFG_LONG_THRESHOLD:      cfg_reg.long_threshold      <= cfg_data[7:0];
                bgc_pkg::CFG_LONG_LONG_THRESHOLD: cfg_reg.long_long_threshold <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

endmodule

FILE: rtl/bgc_core.sv
// gesture state and per-item update logic
`include "button_gesture_classifier_top_defines.svh"

module bgc_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [1:0]       req_type,
    input  logic             button_level,
    input  bgc_pkg::cfg_t    cfg,
    output bgc_pkg::result_t result
);

    logic        seen_held_reg, seen_held_next;
    logic        long_reported_reg, long_reported_next;
    logic        double_reported_reg, double_reported_next;
    logic        window_open_reg, window_open_next;
    logic        press_active_reg, press_active_next;
    logic        period_running_reg, period_running_next;
    logic [15:0] period_phase_reg, period_phase_next;
    logic [7:0]  held_periods_reg, held_periods_next;
    logic [15:0] window_elapsed_reg, window_elapsed_next;

    logic [15:0] period_lim;
    logic [15:0] window_lim;
    logic [15:0] phase_inc;
    logic [15:0] elapsed_inc;
    logic [7:0]  held_inc;

    // zero limits act as one
    assign period_lim  = (cfg.long_period_ticks == 16'd0) ? 16'd1 : cfg.long_period_ticks;
    assign window_lim  = (cfg.double_window_ticks == 16'd0) ? 16'd1 : cfg.double_window_ticks;
    assign phase_inc   = period_phase_reg + 16'd1;
    assign elapsed_inc = window_elapsed_reg + 16'd1;
    assign held_inc    = (held_periods_reg < bgc_pkg::HELD_MAX) ? held_periods_reg + 8'd1
                                                               : held_periods_reg;

    always_comb
    begin
        seen_held_next       = seen_held_reg;
        long_reported_next   = long_reported_reg;
        double_reported_next = double_reported_reg;
        window_open_next     = window_open_reg;
        press_active_next    = press_active_reg;
        period_running_next  = period_running_reg;
        period_phase_next    = period_phase_reg;
        held_periods_next    = held_periods_reg;
        window_elapsed_next  = window_elapsed_reg;
        result.valid         = 1'b0;
        result.code          = bgc_pkg::GESTURE_CLICK;

        if (accept)
        begin
            unique case (bgc_pkg::req_t'(req_type))
                bgc_pkg::REQ_TICK:
                begin
                    // window advances first, then the period timer
                    if (window_open_reg)
                    begin
                        window_elapsed_next = elapsed_inc;
                        if (elapsed_inc >= window_lim)
                        begin
                            window_open_next    = 1'b0;
                            window_elapsed_next = 16'd0;
                        end
                    end
                    if (period_running_reg)
                    begin
                        period_phase_next = phase_inc;
                        if (phase_inc >= period_lim)
                        begin
                            period_phase_next = 16'd0;
                            if (!button_level)
                            begin
                                period_running_next = 1'b0;
                                press_active_next   = 1'b0;
                                held_periods_next   = 8'd0;
                            end
                            else if (press_active_reg)
                            begin
                                seen_held_next    = 1'b1;
                                held_periods_next = held_inc;
                                if (held_inc > cfg.long_long_threshold)
                                begin
                                    seen_held_next      = 1'b0;
                                    period_running_next = 1'b0;
                                    press_active_next   = 1'b0;
                                    result.valid        = 1'b1;
                                    result.code         = bgc_pkg::GESTURE_LONG_LONG;
                                end
                                else if (held_inc > cfg.long_threshold && !long_reported_reg)
                                begin
                                    long_reported_next = 1'b1;
                                    result.valid       = 1'b1;
                                    result.code        = bgc_pkg::GESTURE_LONG;
                                end
                            end
                        end
                    end
                end
                bgc_pkg::REQ_PUSH:
                begin
                    press_active_next    = 1'b1;
                    held_periods_next    = 8'd0;
                    long_reported_next   = 1'b0;
                    double_reported_next = 1'b0;
                    period_running_next  = 1'b1;
                    period_phase_next    = 16'd0;
                    window_elapsed_next  = 16'd0;
                    if (!window_open_reg)
                    begin
                        window_open_next = 1'b1;
                    end
                    else
                    begin
                        // second push inside the window
                        seen_held_next       = 1'b0;
                        press_active_next    = 1'b0;
                        double_reported_next = 1'b1;
                        window_open_next     = 1'b0;
                        result.valid         = 1'b1;
                        result.code          = bgc_pkg::GESTURE_DOUBLE;
                    end
                end
                bgc_pkg::REQ_RELEASE:
                begin
                    if (seen_held_reg && !long_reported_reg && !double_reported_reg)
                    begin
                        result.valid = 1'b1;
                        result.code  = bgc_pkg::GESTURE_CLICK;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_held_reg       <= 1'b0;
            long_reported_reg   <= 1'b0;
            double_reported_reg <= 1'b0;
            window_open_reg     <= 1'b0;
            press_active_reg    <= 1'b0;
            period_running_reg  <= 1'b0;
            period_phase_reg    <= 16'd0;
            held_periods_reg    <= 8'd0;
            window_elapsed_reg  <= 16'd0;
        end
        else
        begin
            seen_held_reg       <= seen_held_next;
            long_reported_reg   <= long_reported_next;
            double_reported_reg <= double_reported_next;
            window_open_reg     <= window_open_next;
            press_active_reg    <= press_active_next;
            period_running_reg  <= period_running_next;
            period_phase_reg    <= period_phase_next;
            held_periods_reg    <= held_periods_next;
            window_elapsed_reg  <= window_elapsed_next;
        end
    end

    `BGC_ASSERT_HOLDS(a_phase_idle, period_running_reg || (period_phase_reg == 16'd0), "phase moved while period timer stopped")
    `BGC_ASSERT_HOLDS(a_window_idle, window_open_reg || (window_elapsed_reg == 16'd0), "window count nonzero while window closed")
    `BGC_ASSERT_HOLDS(a_double_push, !(accept && (req_type == bgc_pkg::REQ_PUSH) && window_open_reg) || (result.valid && (result.code == bgc_pkg::GESTURE_DOUBLE)), "push in open window gave no double click")
    `BGC_ASSERT_NEXT(a_long_long_ends, result.valid && (result.code == bgc_pkg::GESTURE_LONG_LONG), !press_active_reg && !period_running_reg && !seen_held_reg, "press not ended after very long press")

endmodule

FILE: rtl/bgc_out_buf.sv
// two-entry result buffer decoupling the output handshake
module bgc_out_buf
(
    input  logic             clk,
    input  logic             rst_n,
    input  bgc_pkg::result_t result,
    output logic             full,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [1:0]       gesture_code
);

    logic [1:0]        count_reg, count_next;
    bgc_pkg::gesture_t slot0_reg, slot0_next;
    bgc_pkg::gesture_t slot1_reg, slot1_next;
    logic              pop;

    assign out_valid    = (count_reg != 2'd0);
    assign full         = (count_reg == 2'd2);
    assign gesture_code = slot0_reg;
    assign pop          = out_valid && !out_stall;

    always_comb
    begin
        count_next = count_reg + {1'b0, result.valid} - {1'b0, pop};
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (pop)
        begin
            if (count_reg == 2'd2)
                slot0_next = slot1_reg;
            else if (result.valid)
                slot0_next = result.code;
        end
        else if (result.valid)
        begin
            if (count_reg == 2'd0)
                slot0_next = result.code;
            else
                slot1_next = result.code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

FILE: tb/bgc_checker.sv
// gesture predictor and result checker for the button gesture classifier testbench
module bgc_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic        button_level,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  gesture_code,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    localparam int PRINT_LIMIT = 40;

    bgc_pkg::gesture_t expected_gestures[$];
    bgc_pkg::cfg_t     cfg;

    logic        held_seen;
    logic        long_done;
    logic        double_done;
    logic        win_open;
    logic        press_on;
    logic        timer_on;
    logic [15:0] phase_cnt;
    logic [7:0]  held_cnt;
    logic [15:0] win_cnt;

    initial fail_count = 0;

    task report_mismatch(input string what);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    // one accepted item: update the gesture state and queue the gesture it reports
    task automatic advance_gesture_state(input logic [1:0] req, input logic lvl);
        logic [15:0] lim;
        case (req)
            bgc_pkg::REQ_TICK:
            begin
                // window first, then the held-period timer
                if (win_open)
                begin
                    lim = (cfg.double_window_ticks == 16'd0) ? 16'd1 : cfg.double_window_ticks;
                    win_cnt++;
                    if (win_cnt >= lim)
                    begin
                        win_open = 1'b0;
                        win_cnt  = '0;
                    end
                end
                if (timer_on)
                begin
                    lim = (cfg.long_period_ticks == 16'd0) ? 16'd1 : cfg.long_period_ticks;
                    phase_cnt++;
                    if (phase_cnt >= lim)
                    begin
                        phase_cnt = '0;
                        if (!lvl)
                        begin
                            timer_on = 1'b0;
                            press_on = 1'b0;
                            held_cnt = '0;
                        end
                        else if (press_on)
                        begin
                            held_seen = 1'b1;
                            if (held_cnt != bgc_pkg::HELD_MAX)
                                held_cnt++;
                            if (held_cnt > cfg.long_long_threshold)
                            begin
                                held_seen = 1'b0;
                                timer_on  = 1'b0;
                                press_on  = 1'b0;
                                expected_gestures.push_back(bgc_pkg::GESTURE_LONG_LONG);
                            end
                            else if (held_cnt > cfg.long_threshold && !long_done)
                            begin
                                long_done = 1'b1;
                                expected_gestures.push_back(bgc_pkg::GESTURE_LONG);
                            end
                        end
                    end
                end
            end
            bgc_pkg::REQ_PUSH:
            begin
                press_on    = 1'b1;
                held_cnt    = '0;
                long_done   = 1'b0;
                double_done = 1'b0;
                timer_on    = 1'b1;
                phase_cnt   = '0;
                if (!win_open)
                begin
                    win_open = 1'b1;
                    win_cnt  = '0;
                end
                else
                begin
                    // second push inside the window
                    held_seen   = 1'b0;
                    press_on    = 1'b0;
                    double_done = 1'b1;
                    win_open    = 1'b0;
                    win_cnt     = '0;
                    expected_gestures.push_back(bgc_pkg::GESTURE_DOUBLE);
                end
            end
            bgc_pkg::REQ_RELEASE:
            begin
                if (held_seen && !long_done && !double_done)
                    expected_gestures.push_back(bgc_pkg::GESTURE_CLICK);
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bgc_pkg::gesture_t want;
        if (!rst_n)
        begin
            cfg.long_period_ticks   = bgc_pkg::LONG_PERIOD_RESET;
            cfg.double_window_ticks = bgc_pkg::DOUBLE_WINDOW_RESET;
            cfg.long_threshold      = bgc_pkg::LONG_THRESH_RESET;
            cfg.long_long_threshold = bgc_pkg::LONG_LONG_RESET;
            held_seen   = 1'b0;
            long_done   = 1'b0;
            double_done = 1'b0;
            win_open    = 1'b0;
            press_on    = 1'b0;
            timer_on    = 1'b0;
            phase_cnt   = '0;
            held_cnt    = '0;
            win_cnt     = '0;
            expected_gestures.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bgc_pkg::CFG_LONG_PERIOD_TICKS:   cfg.long_period_ticks   = cfg_data;
                    bgc_pkg::CFG_DOUBLE_WINDOW_TICKS: cfg.double_window_ticks = cfg_data;
                    bgc_pkg::CFG_LONG_THRESHOLD:      cfg.long_threshold      = cfg_data[7:0];
                    bgc_pkg::CFG_LONG_LONG_THRESHOLD: cfg.long_long_threshold = cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && !in_stall)
                advance_gesture_state(req_type, button_level);
            if (out_valid && !out_stall)
            begin
                if (expected_gestures.size() == 0)
                    report_mismatch($sformatf("gesture_code %0d with nothing expected",
                                              gesture_code));
                else
                begin
                    want = expected_gestures.pop_front();
                    if (gesture_code !== want)
                        report_mismatch($sformatf("gesture_code %0d, expected %s",
                                                  gesture_code, want.name()));
                end
            end
            pending <= expected_gestures.size();
        end
    end

endmodule

FILE: tb/tb.sv
// testbench top: stimulus, idling, watchdog and verdict for the button gesture classifier
module tb;

    localparam int         IDLE_LIMIT = 1000;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic [1:0]  req_type     = bgc_pkg::REQ_TICK;
    logic        button_level = 1'b0;
    logic        out_stall    = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic [1:0]  cfg_index    = bgc_pkg::CFG_LONG_PERIOD_TICKS;
    logic [15:0] cfg_data     = '0;
    wire         in_stall;
    wire         out_valid;
    wire  [1:0]  gesture_code;
    wire         cfg_ready;

    int fail_count;
    int pending;

    int burst_left  = 0;
    int items_sent  = 0;
    int idle_cycles = 0;
    int stall_mode  = 0;
    int mode_left   = 0;
    int cycle_cnt   = 0;

    // current settings, used to size holds and gaps
    int cur_period = bgc_pkg::LONG_PERIOD_RESET;
    int cur_window = bgc_pkg::DOUBLE_WINDOW_RESET;
    int cur_llt    = bgc_pkg::LONG_LONG_RESET;

    button_gesture_classifier_top u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .button_level (button_level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .gesture_code (gesture_code),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    bgc_checker u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .button_level (button_level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .gesture_code (gesture_code),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // receiver stall pattern, switching at random among four stall modes
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(32, 256);
        end
        else
            mode_left <= mode_left - 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ((cycle_cnt % 11) < 4);
        endcase
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input logic [1:0] req, input logic lvl);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid     <= 1'b1;
        req_type     <= req;
        button_level <= lvl;
        do
            @(posedge clk);
        while (in_stall);
        burst_left--;
        if (req != REQ_UNUSED)
            items_sent++;
    endtask

    task automatic ticks(input int n, input logic lvl);
        for (int i = 0; i < n; i++)
            send_item(bgc_pkg::REQ_TICK, lvl);
    endtask

    // level is meaningless on edges, so it is randomized there
    task automatic push_edge();
        send_item(bgc_pkg::REQ_PUSH, 1'($urandom_range(0, 1)));
    endtask

    task automatic release_edge();
        send_item(bgc_pkg::REQ_RELEASE, 1'($urandom_range(0, 1)));
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // thresholds carry random upper bits that the block must drop
    task automatic load_settings(input int period, input int window, input int lt, input int llt);
        put_reg(bgc_pkg::CFG_LONG_PERIOD_TICKS, 16'(period));
        put_reg(bgc_pkg::CFG_DOUBLE_WINDOW_TICKS, 16'(window));
        put_reg(bgc_pkg::CFG_LONG_THRESHOLD, {8'($urandom), 8'(lt)});
        put_reg(bgc_pkg::CFG_LONG_LONG_THRESHOLD, {8'($urandom), 8'(llt)});
        cfg_valid  <= 1'b0;
        cur_period = (period == 0) ? 1 : period;
        cur_window = window;
        cur_llt    = llt;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic press_and_hold(input int hold);
        push_edge();
        for (int i = 0; i < hold; i++)
            send_item(bgc_pkg::REQ_TICK, ($urandom_range(0, 29) == 0) ? 1'b0 : 1'b1);
        release_edge();
    endtask

    task automatic run_phase(input int budget);
        int first;
        int max_hold;
        int max_gap;
        first    = items_sent;
        max_hold = (cur_llt + 2) * cur_period + 2;
        if (max_hold > 200)
            max_hold = 200;
        max_gap = (cur_window > 20) ? 23 : cur_window + 3;
        while (items_sent - first < budget)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    press_and_hold($urandom_range(0, max_hold));
                    ticks($urandom_range(0, max_gap), 1'b0);
                end
                6, 7:
                begin
                    // double click, then the held timer keeps running
                    press_and_hold($urandom_range(0, max_gap));
                    press_and_hold($urandom_range(0, max_hold));
                    ticks($urandom_range(0, max_gap), 1'b0);
                end
                default:
                begin
                    repeat ($urandom_range(1, 6))
                        send_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
                end
            endcase
        end
    endtask

    initial
    begin
        int lt;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: no period fires, second push gives a double click
        push_edge();
        ticks(3, 1'b1);
        release_edge();
        push_edge();
        release_edge();
        ticks(1, 1'b0);
        send_item(REQ_UNUSED, 1'b1);
        send_item(REQ_UNUSED, 1'b0);
        send_item(bgc_pkg::REQ_RELEASE, 1'b1);
        settle();

        // zero period and zero window: long and very long on consecutive ticks
        load_settings(0, 0, 0, 1);
        push_edge();
        ticks(2, 1'b1);
        release_edge();
        push_edge();
        ticks(1, 1'b0);
        push_edge();
        ticks(1, 1'b1);
        release_edge();
        settle();

        // click, then double click with the timer left running
        load_settings(1, 3, 2, 4);
        push_edge();
        ticks(2, 1'b1);
        release_edge();
        push_edge();
        ticks(1, 1'b1);
        ticks(1, 1'b0);
        release_edge();
        settle();

        load_settings(16'hFFFF, 16'hFFFF, 254, 254);
        run_phase(60);
        settle();

        // held counter saturates; very long press can never fire
        load_settings(0, 1, 254, 255);
        push_edge();
        ticks(300, 1'b1);
        release_edge();
        ticks(2, 1'b0);
        settle();

        for (int p = 0; p < 8; p++)
        begin
            lt = $urandom_range(0, 10);
            load_settings($urandom_range(0, 4), $urandom_range(0, 12), lt, $urandom_range(0, 24));
            run_phase(170);
            settle();
        end

        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/bgc_pkg.sv
rtl/bgc_cfg_regs.sv
rtl/bgc_core.sv
rtl/bgc_out_buf.sv
rtl/button_gesture_classifier_top.sv
tb/bgc_checker.sv
tb/tb.sv
